>>> design/ecef_enu_frame_rotation_defines.svh
// Assertion macros shared by the frame rotation modules.
`ifndef ECEF_ENU_FRAME_ROTATION_DEFINES_SVH
`define ECEF_ENU_FRAME_ROTATION_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define EFR_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define EFR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/efr_pkg.sv
package efr_pkg;

    // Fixed widths of the configuration registers.
    localparam int REF_W     = 34;
    localparam int TRIG_W    = 32;
    localparam int CFG_IDX_W = 3;

    // Number of register stages from the input to the output register.
    localparam int STAGES = 6;

    // Reset value of the cosine registers: 1.0 in Q2.30.
    localparam logic signed [TRIG_W-1:0] TRIG_ONE = 32'sh4000_0000;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_REF_POS_X   = 3'd0,
        REG_REF_POS_Y   = 3'd1,
        REG_REF_POS_Z   = 3'd2,
        REG_SIN_REF_LAT = 3'd3,
        REG_COS_REF_LAT = 3'd4,
        REG_SIN_REF_LON = 3'd5,
        REG_COS_REF_LON = 3'd6
    } cfg_reg_t;

    // Load enables of the lane stages.
    typedef struct packed {
        logic en_mul;
        logic en_prod;
        logic en_sum;
        logic en_fin;
    } pipe_en_t;

endpackage

>>> design/efr_coef.sv
module efr_coef
    import efr_pkg::*;
#(
    parameter int TRIG_FRAC_BITS = 30,
    localparam int CW = 2 * TRIG_W - TRIG_FRAC_BITS
)(
    input  logic                     aclk,
    input  logic signed [TRIG_W-1:0] sin_lat,
    input  logic signed [TRIG_W-1:0] cos_lat,
    input  logic signed [TRIG_W-1:0] sin_lon,
    input  logic signed [TRIG_W-1:0] cos_lon,
    output logic signed [CW-1:0]     rot_out [3][3]
);

    localparam int PW = 2 * TRIG_W;

    logic signed [PW-1:0] p_slcl_reg, p_slsl_reg, p_clcl_reg, p_clsl_reg;
    logic signed [CW-1:0] rot_next [3][3];
    logic signed [CW-1:0] rot_reg  [3][3];

    // Rounds a trig product back to the trig fraction width, half up.
    function automatic logic signed [CW-1:0] coef_round(input logic signed [PW-1:0] p);
        logic signed [PW-1:0] s;
        s = (p + (PW'(1) <<< (TRIG_FRAC_BITS - 1))) >>> TRIG_FRAC_BITS;
        return s[CW-1:0];
    endfunction

    // Trig products, one multiplier each.
    always_ff @(posedge aclk) begin
        p_slcl_reg <= sin_lat * cos_lon;
        p_slsl_reg <= sin_lat * sin_lon;
        p_clcl_reg <= cos_lat * cos_lon;
        p_clsl_reg <= cos_lat * sin_lon;
    end

    // Rotation matrix rows east, north and up.
    always_comb begin
        rot_next[0][0] = -CW'(sin_lon);
        rot_next[0][1] = CW'(cos_lon);
        rot_next[0][2] = '0;
        rot_next[1][0] = -coef_round(p_slcl_reg);
        rot_next[1][1] = -coef_round(p_slsl_reg);
        rot_next[1][2] = CW'(cos_lat);
        rot_next[2][0] = coef_round(p_clcl_reg);
        rot_next[2][1] = coef_round(p_clsl_reg);
        rot_next[2][2] = CW'(sin_lat);
    end

    always_ff @(posedge aclk) begin
        rot_reg <= rot_next;
    end

    assign rot_out = rot_reg;

endmodule

>>> design/efr_lane.sv
module efr_lane
    import efr_pkg::*;
#(
    parameter int COORD_BITS     = 36,
    parameter int TRIG_FRAC_BITS = 30,
    localparam int VW = ((COORD_BITS > REF_W) ? COORD_BITS : REF_W) + 1,
    localparam int CW = 2 * TRIG_W - TRIG_FRAC_BITS
)(
    input  logic                         aclk,
    input  pipe_en_t                     en,
    input  logic                         cmd_in,
    input  logic signed [VW-1:0]         vec_in   [3],
    input  logic signed [CW-1:0]         row_in   [3],
    input  logic signed [CW-1:0]         col_in   [3],
    input  logic signed [REF_W-1:0]      base_pos,
    output logic signed [COORD_BITS-1:0] res_out,
    output logic                         clip_out
);

    // Operand halves for the partial products.
    localparam int CL = CW / 2;
    localparam int CH = CW - CL;
    localparam int VL = VW / 2;
    localparam int VH = VW - VL;
    localparam int PW = CW + VW;
    localparam int AW = PW + 2;
    localparam int SW = AW - TRIG_FRAC_BITS + 1;

    logic signed [CW-1:0]         c_sel [3];
    logic signed [CH+VH-1:0]      pp_hh_next [3], pp_hh_reg [3];
    logic signed [CH+VL:0]        pp_hl_next [3], pp_hl_reg [3];
    logic signed [CL+VH:0]        pp_lh_next [3], pp_lh_reg [3];
    logic        [CL+VL-1:0]      pp_ll_next [3], pp_ll_reg [3];
    logic signed [PW-1:0]         prod_next [3], prod_reg [3];
    logic signed [AW-1:0]         acc_next, acc_reg;
    logic signed [SW-1:0]         sum_fin;
    logic                         fits;
    logic signed [COORD_BITS-1:0] res_next, res_reg;
    logic                         clip_next, clip_reg;
    logic                         cmd_s2_reg, cmd_s3_reg, cmd_s4_reg;

    // Coefficient choice and partial products: the row for the forward
    // direction, the column (transpose) for the inverse.
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            c_sel[j]      = cmd_in ? col_in[j] : row_in[j];
            pp_hh_next[j] = $signed(c_sel[j][CW-1:CL]) * $signed(vec_in[j][VW-1:VL]);
            pp_hl_next[j] = $signed(c_sel[j][CW-1:CL]) * $signed({1'b0, vec_in[j][VL-1:0]});
            pp_lh_next[j] = $signed({1'b0, c_sel[j][CL-1:0]}) * $signed(vec_in[j][VW-1:VL]);
            pp_ll_next[j] = c_sel[j][CL-1:0] * vec_in[j][VL-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en.en_mul) begin
            pp_hh_reg  <= pp_hh_next;
            pp_hl_reg  <= pp_hl_next;
            pp_lh_reg  <= pp_lh_next;
            pp_ll_reg  <= pp_ll_next;
            cmd_s2_reg <= cmd_in;
        end
    end

    // Full products from the partial products.
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            prod_next[j] = (PW'(pp_hh_reg[j]) <<< (CL + VL))
                         + (PW'(pp_hl_reg[j]) <<< CL)
                         + (PW'(pp_lh_reg[j]) <<< VL)
                         + PW'(pp_ll_reg[j]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en.en_prod) begin
            prod_reg   <= prod_next;
            cmd_s3_reg <= cmd_s2_reg;
        end
    end

    // Exact dot product plus the rounding half.
    assign acc_next = AW'(prod_reg[0]) + AW'(prod_reg[1]) + AW'(prod_reg[2])
                    + (AW'(1) <<< (TRIG_FRAC_BITS - 1));

    always_ff @(posedge aclk) begin
        if (en.en_sum) begin
            acc_reg    <= acc_next;
            cmd_s4_reg <= cmd_s3_reg;
        end
    end

    // Drop the fraction, add the reference point when going back to ECEF,
    // and clamp to the coordinate range.
    always_comb begin
        sum_fin = SW'($signed(acc_reg[AW-1:TRIG_FRAC_BITS]))
                + (cmd_s4_reg ? SW'(base_pos) : SW'(0));
        fits    = (&sum_fin[SW-1:COORD_BITS-1]) || !(|sum_fin[SW-1:COORD_BITS-1]);
        if (fits) begin
            res_next = sum_fin[COORD_BITS-1:0];
        end else begin
            res_next = {sum_fin[SW-1], {(COORD_BITS-1){~sum_fin[SW-1]}}};
        end
        clip_next = !fits;
    end

    always_ff @(posedge aclk) begin
        if (en.en_fin) begin
            res_reg  <= res_next;
            clip_reg <= clip_next;
        end
    end

    assign res_out  = res_reg;
    assign clip_out = clip_reg;

endmodule

>>> design/efr_merge.sv
`include "ecef_enu_frame_rotation_defines.svh"

module efr_merge
    import efr_pkg::*;
#(
    parameter int COORD_BITS = 36,
    localparam int ODW = ((3 * COORD_BITS + 7) / 8) * 8
)(
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         load,
    input  logic                         out_valid,
    input  logic signed [COORD_BITS-1:0] res_in  [3],
    input  logic                         clip_in [3],
    output logic [ODW-1:0]               tdata,
    output logic [0:0]                   tuser
);

    localparam logic signed [COORD_BITS-1:0] RES_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [COORD_BITS-1:0] RES_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

    logic [ODW-1:0] tdata_next, tdata_reg;
    logic           clip_next, clip_reg;
    logic           at_limit;

    // Pack the three components and fold the lane clip flags together.
    always_comb begin
        tdata_next = ODW'({res_in[2], res_in[1], res_in[0]});
        clip_next  = clip_in[0] || clip_in[1] || clip_in[2];
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            tdata_reg <= tdata_next;
            clip_reg  <= clip_next;
        end
    end

    assign tdata = tdata_reg;
    assign tuser = clip_reg;

    // Some component sits on a range limit.
    always_comb begin
        at_limit = 1'b0;
        for (int k = 0; k < 3; k++) begin
            if ((tdata_reg[k*COORD_BITS +: COORD_BITS] == RES_MAX)
                || (tdata_reg[k*COORD_BITS +: COORD_BITS] == RES_MIN)) begin
                at_limit = 1'b1;
            end
        end
    end

    `EFR_ASSERT_SAME(a_clip_at_limit, aclk, aresetn, out_valid && clip_reg, at_limit, "clipped flag set but no component at a range limit")

endmodule

>>> design/ecef_enu_frame_rotation.sv
// A beat passes the front, partial product, product, sum, result and output registers.
// One beat per cycle barring stalls; the three lanes and output register run in parallel.
// After a configuration write, input is held off in the following cycle while the matrix settles.
// Reset (aresetn, synchronous, active low) empties the pipeline, restores the register
// reset values and holds off input for the first cycle after reset.
`include "ecef_enu_frame_rotation_defines.svh"

module ecef_enu_frame_rotation
    import efr_pkg::*;
#(
    parameter int COORD_BITS     = 36,
    parameter int TRIG_FRAC_BITS = 30,
    localparam int DW = ((3 * COORD_BITS + 7) / 8) * 8
)(
    input  logic                 aclk,
    input  logic                 aresetn,
    // Input beats.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [DW-1:0]        s_tdata,   // coord_a, coord_b, coord_c, zero fill
    input  logic [0:0]           s_tuser,   // command
    // Result beats.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [DW-1:0]        m_tdata,   // result_a, result_b, result_c, zero fill
    output logic [0:0]           m_tuser,   // clipped
    // Register writes.
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [REF_W-1:0]     cfg_data
);

    localparam int VW = ((COORD_BITS > REF_W) ? COORD_BITS : REF_W) + 1;
    localparam int CW = 2 * TRIG_W - TRIG_FRAC_BITS;

    logic signed [REF_W-1:0]      refpos_reg [3];
    logic signed [TRIG_W-1:0]     sin_lat_reg, cos_lat_reg, sin_lon_reg, cos_lon_reg;
    logic                         cfg_we;
    logic                         hold_reg;
    logic [STAGES-1:0]            v_reg, v_next, adv;
    logic                         s_fire;
    logic                         cmd_reg;
    logic signed [VW-1:0]         vec_next [3], vec_reg [3];
    logic signed [CW-1:0]         rot [3][3];
    pipe_en_t                     lane_en;
    logic signed [COORD_BITS-1:0] lane_res [3];
    logic                         lane_clip [3];

    // Register writes; indexes beyond the list are dropped.
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            refpos_reg[0] <= '0;
            refpos_reg[1] <= '0;
            refpos_reg[2] <= '0;
            sin_lat_reg   <= '0;
            cos_lat_reg   <= TRIG_ONE;
            sin_lon_reg   <= '0;
            cos_lon_reg   <= TRIG_ONE;
        end else if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_REF_POS_X:   refpos_reg[0] <= cfg_data;
                REG_REF_POS_Y:   refpos_reg[1] <= cfg_data;
                REG_REF_POS_Z:   refpos_reg[2] <= cfg_data;
                REG_SIN_REF_LAT: sin_lat_reg   <= cfg_data[TRIG_W-1:0];
                REG_COS_REF_LAT: cos_lat_reg   <= cfg_data[TRIG_W-1:0];
                REG_SIN_REF_LON: sin_lon_reg   <= cfg_data[TRIG_W-1:0];
                REG_COS_REF_LON: cos_lon_reg   <= cfg_data[TRIG_W-1:0];
                default: ;
            endcase
        end
    end

    // The matrix lags the trig registers; hold input off meanwhile.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_reg <= 1'b1;
        end else begin
            hold_reg <= cfg_we;
        end
    end

    // Stage advance: a stage moves on when it is empty or the next one moves.
    always_comb begin
        adv[STAGES-1] = !v_reg[STAGES-1] || m_tready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            adv[k] = !v_reg[k] || adv[k+1];
        end
    end

    assign s_tready = adv[0] && !hold_reg;
    assign s_fire   = s_tvalid && s_tready;

    always_comb begin
        v_next[0] = adv[0] ? s_fire : v_reg[0];
        for (int k = 1; k < STAGES; k++) begin
            v_next[k] = adv[k] ? v_reg[k-1] : v_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= v_next;
        end
    end

    assign m_tvalid = v_reg[STAGES-1];

    // Front stage: offset from the reference point for the forward direction.
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            if (s_tuser[0]) begin
                vec_next[j] = VW'($signed(s_tdata[j*COORD_BITS +: COORD_BITS]));
            end else begin
                vec_next[j] = VW'($signed(s_tdata[j*COORD_BITS +: COORD_BITS]))
                            - VW'(refpos_reg[j]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            cmd_reg <= s_tuser[0];
            vec_reg <= vec_next;
        end
    end

    // Rotation matrix from the trig registers.
    efr_coef #(
        .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
    ) u_coef (
        .aclk    (aclk),
        .sin_lat (sin_lat_reg),
        .cos_lat (cos_lat_reg),
        .sin_lon (sin_lon_reg),
        .cos_lon (cos_lon_reg),
        .rot_out (rot)
    );

    assign lane_en.en_mul  = adv[1];
    assign lane_en.en_prod = adv[2];
    assign lane_en.en_sum  = adv[3];
    assign lane_en.en_fin  = adv[4];

    // One lane per result component.
    for (genvar g = 0; g < 3; g++) begin : g_lane
        logic signed [CW-1:0] row_g [3];
        logic signed [CW-1:0] col_g [3];

        always_comb begin
            for (int j = 0; j < 3; j++) begin
                row_g[j] = rot[g][j];
                col_g[j] = rot[j][g];
            end
        end

        efr_lane #(
            .COORD_BITS     (COORD_BITS),
            .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
        ) u_lane (
            .aclk     (aclk),
            .en       (lane_en),
            .cmd_in   (cmd_reg),
            .vec_in   (vec_reg),
            .row_in   (row_g),
            .col_in   (col_g),
            .base_pos (refpos_reg[g]),
            .res_out  (lane_res[g]),
            .clip_out (lane_clip[g])
        );
    end

    // Output register and clip merge.
    efr_merge #(
        .COORD_BITS(COORD_BITS)
    ) u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (adv[STAGES-1]),
        .out_valid (m_tvalid),
        .res_in    (lane_res),
        .clip_in   (lane_clip),
        .tdata     (m_tdata),
        .tuser     (m_tuser)
    );

    `EFR_ASSERT_NEXT(a_hold_after_cfg, aclk, aresetn, cfg_we, !s_tready, "input accepted while the matrix settles")
    `EFR_ASSERT_NEXT(a_fire_enters, aclk, aresetn, s_fire, v_reg[0], "accepted beat did not enter the front stage")

endmodule

>>> bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import efr_pkg::*;

    localparam int COORD_W     = 36;
    localparam int FRAC        = 30;
    localparam int DW          = ((3 * COORD_W + 7) / 8) * 8;
    localparam int QUIET_LIMIT = 1000;

    localparam logic signed [COORD_W-1:0] COORD_MAX = 36'sh7_FFFF_FFFF;
    localparam logic signed [COORD_W-1:0] COORD_MIN = 36'sh8_0000_0000;
    localparam logic signed [REF_W-1:0]   REF_MAX   = 34'sh1_FFFF_FFFF;
    localparam logic signed [REF_W-1:0]   REF_MIN   = 34'sh2_0000_0000;
    localparam logic signed [TRIG_W-1:0]  TRIG_HALF = 32'sh2000_0000;
    localparam logic signed [TRIG_W-1:0]  TRIG_MIN  = 32'sh8000_0000;
    localparam logic signed [TRIG_W-1:0]  TRIG_MAX  = 32'sh7FFF_FFFF;

    // Register index with no register behind it; writes to it must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

    // One expected result beat.
    typedef struct packed {
        logic                clipped;
        logic [COORD_W-1:0]  result_c;
        logic [COORD_W-1:0]  result_b;
        logic [COORD_W-1:0]  result_a;
    } point_t;

    // Holds a copy of the registers, works out each converted point and
    // compares the result beats against the points still due.
    class point_transform;
        logic signed [REF_W-1:0]  ref_pos [3];
        logic signed [TRIG_W-1:0] s_lat, c_lat, s_lon, c_lon;
        point_t due_points [$];
        int mismatch_count;
        int checked_count;

        function new();
            for (int i = 0; i < 3; i++) ref_pos[i] = '0;
            s_lat = '0;
            c_lat = TRIG_ONE;
            s_lon = '0;
            c_lon = TRIG_ONE;
            mismatch_count = 0;
            checked_count = 0;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [REF_W-1:0] data);
            case (cfg_reg_t'(idx))
                REG_REF_POS_X:   ref_pos[0] = data;
                REG_REF_POS_Y:   ref_pos[1] = data;
                REG_REF_POS_Z:   ref_pos[2] = data;
                REG_SIN_REF_LAT: s_lat = data[TRIG_W-1:0];
                REG_COS_REF_LAT: c_lat = data[TRIG_W-1:0];
                REG_SIN_REF_LON: s_lon = data[TRIG_W-1:0];
                REG_COS_REF_LON: c_lon = data[TRIG_W-1:0];
                default: ;
            endcase
        endfunction

        // Product of two trig values, rounded half up back to the trig format.
        function logic signed [39:0] blend(logic signed [TRIG_W-1:0] p, q);
            logic signed [65:0] prod;
            prod = p * q;
            prod = prod + (66'sd1 <<< (FRAC - 1));
            return prod >>> FRAC;
        endfunction

        function void predict_point(logic cmd, logic signed [COORD_W-1:0] a, b, c);
            logic signed [39:0] rot [3][3];
            logic signed [95:0] vec [3];
            logic signed [95:0] acc, cw, top, bottom;
            logic [COORD_W-1:0] res [3];
            logic clip;
            point_t pt;
            top = COORD_MAX;
            bottom = COORD_MIN;
            clip = 1'b0;

            // Rows east, north and up of the rotation.
            rot[0][0] = s_lon;
            rot[0][0] = -rot[0][0];
            rot[0][1] = c_lon;
            rot[0][2] = '0;
            rot[1][0] = -blend(s_lat, c_lon);
            rot[1][1] = -blend(s_lat, s_lon);
            rot[1][2] = c_lat;
            rot[2][0] = blend(c_lat, c_lon);
            rot[2][1] = blend(c_lat, s_lon);
            rot[2][2] = s_lat;

            vec[0] = a;
            vec[1] = b;
            vec[2] = c;
            if (!cmd) begin
                for (int j = 0; j < 3; j++) vec[j] = vec[j] - ref_pos[j];
            end

            // Exact sum of three products, one rounding, then the offset and the clamp.
            for (int k = 0; k < 3; k++) begin
                acc = '0;
                for (int j = 0; j < 3; j++) begin
                    cw = cmd ? rot[j][k] : rot[k][j];
                    acc = acc + cw * vec[j];
                end
                acc = (acc + (96'sd1 <<< (FRAC - 1))) >>> FRAC;
                if (cmd) acc = acc + ref_pos[k];
                if (acc > top) begin
                    res[k] = COORD_MAX;
                    clip = 1'b1;
                end else if (acc < bottom) begin
                    res[k] = COORD_MIN;
                    clip = 1'b1;
                end else begin
                    res[k] = acc[COORD_W-1:0];
                end
            end
            pt.result_a = res[0];
            pt.result_b = res[1];
            pt.result_c = res[2];
            pt.clipped = clip;
            due_points.push_back(pt);
        endfunction

        function void check_field(string name, logic signed [COORD_W-1:0] want, got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                mismatch_count++;
            end
        endfunction

        function void compare_point(logic [DW-1:0] data, logic clip_bit);
            point_t pt;
            if (due_points.size() == 0) begin
                $error("result beat arrived with no point due");
                mismatch_count++;
                return;
            end
            pt = due_points.pop_front();
            checked_count++;
            check_field("result_a", pt.result_a, data[COORD_W-1:0]);
            check_field("result_b", pt.result_b, data[2*COORD_W-1:COORD_W]);
            check_field("result_c", pt.result_c, data[3*COORD_W-1:2*COORD_W]);
            check_field("clipped", {35'd0, pt.clipped}, {35'd0, clip_bit});
        endfunction
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [DW-1:0]        s_tdata = '0;
    logic [0:0]           s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [DW-1:0]        m_tdata;
    logic [0:0]           m_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [REF_W-1:0]     cfg_data = '0;

    point_transform transform;
    logic signed [REF_W-1:0] cur_ref [3];
    int gap_odds = 0;
    int stall_odds = 4;
    int stall_left = 0;
    int quiet_cycles = 0;
    int settings_loaded = 1;

    ecef_enu_frame_rotation uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    // Watch all three channels; every accepted beat goes to the model.
    always @(posedge aclk) begin
        if (aresetn && cfg_valid && cfg_ready)
            transform.write_register(cfg_index, cfg_data);
        if (aresetn && s_tvalid && s_tready)
            transform.predict_point(s_tuser[0], s_tdata[COORD_W-1:0],
                                    s_tdata[2*COORD_W-1:COORD_W],
                                    s_tdata[3*COORD_W-1:2*COORD_W]);
        if (aresetn && m_tvalid && m_tready)
            transform.compare_point(m_tdata, m_tuser[0]);
    end

    // Receiver back-pressure in random bursts.
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
            m_tready <= 1'b0;
            stall_left <= $urandom_range(0, 14);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Give up when no beat moves on any channel for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one point and hold it until it is taken; valid stays high on return.
    task automatic send_point(logic cmd, logic signed [COORD_W-1:0] a, b, c);
        s_tvalid <= 1'b1;
        s_tdata <= {4'b0, c, b, a};
        s_tuser <= cmd;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic pause_sender();
        if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
    endtask

    // Stop sending and wait until every point due has come back.
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (transform.due_points.size() != 0);
    endtask

    // Write all registers in index order and then the spare index.
    task automatic load_setting(logic signed [REF_W-1:0] rx, ry, rz,
                                logic signed [TRIG_W-1:0] sla, cla, slo, clo);
        logic [REF_W-1:0] vals [8];
        logic [1:0] junk;
        logic [63:0] raw;
        junk = $urandom_range(0, 3);
        raw = {$urandom, $urandom};
        vals[REG_REF_POS_X]   = rx;
        vals[REG_REF_POS_Y]   = ry;
        vals[REG_REF_POS_Z]   = rz;
        // The two top data bits of a trig write carry no meaning.
        vals[REG_SIN_REF_LAT] = {junk, sla};
        vals[REG_COS_REF_LAT] = {~junk, cla};
        vals[REG_SIN_REF_LON] = {junk, slo};
        vals[REG_COS_REF_LON] = {~junk, clo};
        vals[REG_SPARE]       = raw[REF_W-1:0];
        cur_ref[0] = rx;
        cur_ref[1] = ry;
        cur_ref[2] = rz;
        for (int i = 0; i < 8; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= i[CFG_IDX_W-1:0];
            cfg_data <= vals[i];
            do @(posedge aclk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        settings_loaded++;
    endtask

    // Random reference point; trig values near the unit range or anywhere.
    task automatic random_setting(bit wide);
        logic [31:0] trig [4];
        logic [63:0] r0, r1, r2;
        r0 = {$urandom, $urandom};
        r1 = {$urandom, $urandom};
        r2 = {$urandom, $urandom};
        for (int i = 0; i < 4; i++)
            trig[i] = wide ? $urandom : ($urandom_range(0, 32'h8000_0000) - 32'h4000_0000);
        load_setting(r0[REF_W-1:0], r1[REF_W-1:0], r2[REF_W-1:0],
                     trig[0], trig[1], trig[2], trig[3]);
    endtask

    // Four times in nine, points close to the reference (or small local offsets), the rest
    // anywhere in range or hard against the limits.
    function automatic logic signed [COORD_W-1:0] pick_coord(logic signed [REF_W-1:0] centre,
                                                             logic cmd);
        logic signed [COORD_W-1:0] off;
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        off = $urandom_range(0, 32'h0020_0000);
        off = off - 36'sh10_0000;
        case ($urandom_range(0, 8))
            0, 1, 2, 3: return cmd ? off : centre + off;
            4, 5, 6:    return raw[COORD_W-1:0];
            7:          return $signed(raw[31:0]);
            default:    return raw[0] ? COORD_MAX - off[7:0] : COORD_MIN + off[7:0];
        endcase
    endfunction

    initial begin
        logic cmd;
        transform = new();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Registers at their reset values.
        send_point(1'b0, 0, 0, 0);
        send_point(1'b1, 0, 0, 0);
        send_point(1'b0, COORD_MAX, COORD_MAX, COORD_MAX);
        send_point(1'b0, COORD_MIN, COORD_MIN, COORD_MIN);
        send_point(1'b1, COORD_MAX, COORD_MIN, 1);
        send_point(1'b0, -1, 1, -1);

        // Trig values of one half, so odd inputs land on rounding ties.
        settle();
        load_setting(0, 0, 0, TRIG_HALF, TRIG_HALF, TRIG_HALF, TRIG_HALF);
        send_point(1'b0, 1, -1, 3);
        send_point(1'b1, -1, -3, 1);
        send_point(1'b0, 3, -5, 7);

        // Largest reference with the most negative trig values.
        settle();
        load_setting(REF_MAX, REF_MAX, REF_MAX, TRIG_MIN, TRIG_MIN, TRIG_MIN, TRIG_MIN);
        send_point(1'b0, COORD_MIN, COORD_MIN, COORD_MIN);
        send_point(1'b1, COORD_MAX, COORD_MAX, COORD_MAX);
        send_point(1'b0, REF_MAX, REF_MAX, REF_MAX);
        send_point(1'b1, 0, 0, 0);

        // Most negative reference with the largest trig values.
        settle();
        load_setting(REF_MIN, REF_MIN, REF_MIN, TRIG_MAX, TRIG_MAX, TRIG_MAX, TRIG_MAX);
        send_point(1'b0, COORD_MAX, COORD_MAX, COORD_MAX);
        send_point(1'b1, COORD_MIN, COORD_MIN, COORD_MIN);
        send_point(1'b0, REF_MIN, REF_MIN, REF_MIN);
        send_point(1'b1, COORD_MAX, COORD_MIN, COORD_MAX);

        // Trig values at exactly plus and minus one.
        settle();
        load_setting(0, 0, 0, TRIG_ONE, 0, -TRIG_ONE, 0);
        send_point(1'b0, 5, -7, 11);
        send_point(1'b1, COORD_MAX, COORD_MIN, COORD_MAX);

        // Random points under a series of random settings; the last phase runs
        // with no idling on either side.
        for (int phase = 0; phase < 7; phase++) begin
            settle();
            random_setting(phase % 3 == 1);
            gap_odds = (phase == 1 || phase == 6) ? 0 : 5;
            stall_odds = (phase == 2 || phase == 6) ? 0 : ((phase == 3) ? 2 : 4);
            for (int n = 0; n < 100; n++) begin
                pause_sender();
                cmd = $urandom_range(0, 1);
                send_point(cmd, pick_coord(cur_ref[0], cmd), pick_coord(cur_ref[1], cmd),
                           pick_coord(cur_ref[2], cmd));
            end
        end

        settle();
        repeat (20) @(posedge aclk);

        $display("Checked %0d points in both directions under %0d register settings,",
                 transform.checked_count, settings_loaded);
        $display("with clamping, rounding ties, trig beyond unity and stalls on both sides.");
        if (transform.mismatch_count == 0 && transform.due_points.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

>>> ecef_enu_frame_rotation.f
+incdir+design
design/efr_pkg.sv
design/efr_coef.sv
design/efr_lane.sv
design/efr_merge.sv
design/ecef_enu_frame_rotation.sv
bench/testbench.sv
